[rtl/uagc_pkg.sv]
// ----------------------------------------------------------------------------
// uagc_pkg
// Types, register indexes and reset constants of the upward AGC block.
// ----------------------------------------------------------------------------
package uagc_pkg;

  parameter int unsigned COEF_FRAC_BITS_DEF = 24;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COEF_W   = 24;
  localparam int unsigned LEVEL_W  = 15;
  localparam int unsigned GAIN_W   = 24;
  localparam int unsigned ENV_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned GAIN_FRAC = 19;
  localparam int unsigned DIV_STEPS = 24;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 24'd524288;

  localparam logic [COEF_W-1:0]  RST_ENV_ATTACK   = 24'd16431304;
  localparam logic [COEF_W-1:0]  RST_ENV_RELEASE  = 24'd16773022;
  localparam logic [COEF_W-1:0]  RST_GAIN_RISE    = 24'd16776517;
  localparam logic [COEF_W-1:0]  RST_GAIN_FALL    = 24'd16672685;
  localparam logic [LEVEL_W-1:0] RST_TARGET_LEVEL = 15'd9175;
  localparam logic [LEVEL_W-1:0] RST_NOISE_FLOOR  = 15'd59;
  localparam logic [GAIN_W-1:0]  RST_MAX_GAIN     = 24'd11534336;
  localparam logic [LEVEL_W-1:0] RST_OUTPUT_LIMIT = 15'd31130;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENV_ATTACK   = 3'd0,
    REG_ENV_RELEASE  = 3'd1,
    REG_GAIN_RISE    = 3'd2,
    REG_GAIN_FALL    = 3'd3,
    REG_TARGET_LEVEL = 3'd4,
    REG_NOISE_FLOOR  = 3'd5,
    REG_MAX_GAIN     = 3'd6,
    REG_OUTPUT_LIMIT = 3'd7
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ENV_MA,
    ST_ENV_MB,
    ST_ENV_SUM,
    ST_GATE,
    ST_DIV,
    ST_CLAMP,
    ST_GAIN_MA,
    ST_GAIN_MB,
    ST_GAIN_SUM,
    ST_OUT_MUL,
    ST_OUT_FIN
  } state_e;

endpackage

[rtl/upward_agc_noise_gate_limiter.sv]
// ----------------------------------------------------------------------------
// upward_agc_noise_gate_limiter
// Upward AGC with envelope follower, noise gate, gain glide and output limit.
// ----------------------------------------------------------------------------
// One sample in, one sample out. Each sample runs through the envelope pole
// (ST_ENV_MA, ST_ENV_MB, ST_ENV_SUM), the noise gate, the restoring divide of
// target by envelope (one quotient bit per cycle), the clamp, the gain pole
// (ST_GAIN_MA, ST_GAIN_MB, ST_GAIN_SUM), and the output product and limiter
// (ST_OUT_MUL, ST_OUT_FIN). A gated sample skips the divide and the clamp; a
// quotient too large for the gain format skips the divide. A new input
// transfer is taken only once the sequencer is back in idle. All products go
// through one shared 32x32 multiplier under a small sequencer; the input
// stalls while a sample is in work. The result sits in an output register, so
// a new sample is taken while the previous one still waits; if that result is
// still not taken when the next finishes, the sequencer holds in its last step.
// ----------------------------------------------------------------------------
module upward_agc_noise_gate_limiter #(
  parameter int unsigned COEF_FRAC_BITS = uagc_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [uagc_pkg::SAMPLE_W-1:0] sample_in_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [uagc_pkg::SAMPLE_W-1:0] sample_out_o,
  input  logic                            cfg_we_i,
  input  logic [uagc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [uagc_pkg::COEF_W-1:0]     cfg_wdata_i
);

  localparam logic [31:0] CoefOne   = 32'(64'd1 << COEF_FRAC_BITS);
  localparam logic [63:0] RoundHalf = 64'd1 << (COEF_FRAC_BITS - 1);
  localparam int unsigned CntW      = $clog2(uagc_pkg::DIV_STEPS);
  localparam logic [CntW-1:0] CntLast = CntW'(uagc_pkg::DIV_STEPS - 1);
  localparam int unsigned GF        = uagc_pkg::GAIN_FRAC;

  // configuration
  logic [uagc_pkg::COEF_W-1:0]  env_attack_q, env_release_q, gain_rise_q, gain_fall_q;
  logic [uagc_pkg::LEVEL_W-1:0] target_level_q, noise_floor_q, output_limit_q;
  logic [uagc_pkg::GAIN_W-1:0]  max_gain_q;

  // state and datapath
  uagc_pkg::state_e state_q, state_d;
  logic [uagc_pkg::ENV_W-1:0]   envelope_q, envelope_d;
  logic [uagc_pkg::GAIN_W-1:0]  gain_q, gain_d;
  logic [uagc_pkg::GAIN_W-1:0]  desired_q, desired_d;
  logic [uagc_pkg::GAIN_W-1:0]  quot_q, quot_d;
  logic [31:0]                  rem_q, rem_d;
  logic [CntW-1:0]              div_cnt_q, div_cnt_d;
  logic [63:0]                  prod_q, prod_d;
  logic [63:0]                  acc_q, acc_d;
  logic [16:0]                  mag_q, mag_d;
  logic                         neg_q, neg_d;
  logic                         out_valid_q, out_valid_d;
  logic [uagc_pkg::SAMPLE_W-1:0] sample_out_q, sample_out_d;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

  logic        in_xfer, out_xfer;
  logic [31:0] u_env, c_env, c_gain, coef_sel;
  logic [63:0] pole_sum;
  logic [32:0] div_t;
  logic [uagc_pkg::GAIN_W-1:0] clamp_lo;
  logic [33:0] lim;
  logic [21:0] q_trunc;
  logic [18:0] q_rem;
  logic        round_up;
  logic [22:0] q_round;
  logic [uagc_pkg::LEVEL_W-1:0] q_fin;
  logic [uagc_pkg::SAMPLE_W-1:0] q_ext;

  assign in_stall_o   = (state_q != uagc_pkg::ST_IDLE);
  assign in_xfer      = in_valid_i && !in_stall_o;
  assign out_valid_o  = out_valid_q;
  assign out_xfer     = out_valid_q && !out_stall_i;
  assign sample_out_o = sample_out_q;

  always_comb begin
    u_env = 32'({mag_q, 16'b0});
    coef_sel = ({1'b0, u_env} > {1'b0, envelope_q}) ? 32'(env_attack_q) : 32'(env_release_q);
    c_env = (coef_sel > CoefOne) ? CoefOne : coef_sel;
    coef_sel = (desired_q < gain_q) ? 32'(gain_fall_q) : 32'(gain_rise_q);
    c_gain = (coef_sel > CoefOne) ? CoefOne : coef_sel;
  end

  always_comb begin
    state_d      = state_q;
    envelope_d   = envelope_q;
    gain_d       = gain_q;
    desired_d    = desired_q;
    quot_d       = quot_q;
    rem_d        = rem_q;
    div_cnt_d    = div_cnt_q;
    prod_d       = prod_q;
    acc_d        = acc_q;
    mag_d        = mag_q;
    neg_d        = neg_q;
    out_valid_d  = out_valid_q && !out_xfer;
    sample_out_d = sample_out_q;
    mul_a        = '0;
    mul_b        = '0;
    pole_sum     = acc_q + prod_q;
    div_t        = {rem_q, 1'b0};
    clamp_lo     = (quot_q < uagc_pkg::GAIN_ONE) ? uagc_pkg::GAIN_ONE : quot_q;
    lim          = {output_limit_q, 19'b0};
    q_trunc      = prod_q[40:GF];
    q_rem        = prod_q[GF-1:0];
    round_up     = (q_rem > 19'h40000) || ((q_rem == 19'h40000) && q_trunc[0]);
    q_round      = {1'b0, q_trunc} + 23'(round_up);
    if (prod_q[40:0] >= 41'(lim)) begin
      q_fin = output_limit_q;
    end else if (q_round > 23'd32767) begin
      q_fin = 15'd32767;
    end else begin
      q_fin = q_round[14:0];
    end
    q_ext = {1'b0, q_fin};

    case (state_q)
      uagc_pkg::ST_IDLE: begin
        if (in_xfer) begin
          neg_d   = sample_in_i[15];
          mag_d   = sample_in_i[15] ? (17'h10000 - {1'b0, sample_in_i}) : {1'b0, sample_in_i};
          state_d = uagc_pkg::ST_ENV_MA;
        end
      end
      uagc_pkg::ST_ENV_MA: begin
        mul_a   = c_env;
        mul_b   = envelope_q;
        prod_d  = mul_p;
        state_d = uagc_pkg::ST_ENV_MB;
      end
      uagc_pkg::ST_ENV_MB: begin
        mul_a   = CoefOne - c_env;
        mul_b   = u_env;
        acc_d   = prod_q + RoundHalf;
        prod_d  = mul_p;
        state_d = uagc_pkg::ST_ENV_SUM;
      end
      uagc_pkg::ST_ENV_SUM: begin
        envelope_d = 32'(pole_sum >> COEF_FRAC_BITS);
        state_d    = uagc_pkg::ST_GATE;
      end
      uagc_pkg::ST_GATE: begin
        if (envelope_q <= {1'b0, noise_floor_q, 16'b0}) begin
          desired_d = uagc_pkg::GAIN_ONE;
          state_d   = uagc_pkg::ST_GAIN_MA;
        end else if (32'({target_level_q, 11'b0}) >= envelope_q) begin
          // quotient would not fit: saturate, the max clamp follows
          quot_d  = '1;
          state_d = uagc_pkg::ST_CLAMP;
        end else begin
          rem_d     = 32'({target_level_q, 11'b0});
          quot_d    = '0;
          div_cnt_d = '0;
          state_d   = uagc_pkg::ST_DIV;
        end
      end
      uagc_pkg::ST_DIV: begin
        if (div_t >= {1'b0, envelope_q}) begin
          rem_d  = 32'(div_t - {1'b0, envelope_q});
          quot_d = {quot_q[uagc_pkg::GAIN_W-2:0], 1'b1};
        end else begin
          rem_d  = div_t[31:0];
          quot_d = {quot_q[uagc_pkg::GAIN_W-2:0], 1'b0};
        end
        div_cnt_d = div_cnt_q + 1'b1;
        if (div_cnt_q == CntLast) begin
          state_d = uagc_pkg::ST_CLAMP;
        end
      end
      uagc_pkg::ST_CLAMP: begin
        desired_d = (clamp_lo > max_gain_q) ? max_gain_q : clamp_lo;
        state_d   = uagc_pkg::ST_GAIN_MA;
      end
      uagc_pkg::ST_GAIN_MA: begin
        mul_a   = c_gain;
        mul_b   = 32'(gain_q);
        prod_d  = mul_p;
        state_d = uagc_pkg::ST_GAIN_MB;
      end
      uagc_pkg::ST_GAIN_MB: begin
        mul_a   = CoefOne - c_gain;
        mul_b   = 32'(desired_q);
        acc_d   = prod_q + RoundHalf;
        prod_d  = mul_p;
        state_d = uagc_pkg::ST_GAIN_SUM;
      end
      uagc_pkg::ST_GAIN_SUM: begin
        gain_d  = 24'(pole_sum >> COEF_FRAC_BITS);
        state_d = uagc_pkg::ST_OUT_MUL;
      end
      uagc_pkg::ST_OUT_MUL: begin
        mul_a   = 32'(mag_q);
        mul_b   = 32'(gain_q);
        prod_d  = mul_p;
        state_d = uagc_pkg::ST_OUT_FIN;
      end
      uagc_pkg::ST_OUT_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          sample_out_d = neg_q ? (16'd0 - q_ext) : q_ext;
          out_valid_d  = 1'b1;
          state_d      = uagc_pkg::ST_IDLE;
        end
      end
      default: state_d = uagc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= uagc_pkg::ST_IDLE;
      envelope_q     <= '0;
      gain_q         <= uagc_pkg::GAIN_ONE;
      div_cnt_q      <= '0;
      out_valid_q    <= 1'b0;
      env_attack_q   <= uagc_pkg::RST_ENV_ATTACK;
      env_release_q  <= uagc_pkg::RST_ENV_RELEASE;
      gain_rise_q    <= uagc_pkg::RST_GAIN_RISE;
      gain_fall_q    <= uagc_pkg::RST_GAIN_FALL;
      target_level_q <= uagc_pkg::RST_TARGET_LEVEL;
      noise_floor_q  <= uagc_pkg::RST_NOISE_FLOOR;
      max_gain_q     <= uagc_pkg::RST_MAX_GAIN;
      output_limit_q <= uagc_pkg::RST_OUTPUT_LIMIT;
    end else begin
      state_q     <= state_d;
      envelope_q  <= envelope_d;
      gain_q      <= gain_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          uagc_pkg::REG_ENV_ATTACK:   env_attack_q   <= cfg_wdata_i;
          uagc_pkg::REG_ENV_RELEASE:  env_release_q  <= cfg_wdata_i;
          uagc_pkg::REG_GAIN_RISE:    gain_rise_q    <= cfg_wdata_i;
          uagc_pkg::REG_GAIN_FALL:    gain_fall_q    <= cfg_wdata_i;
          uagc_pkg::REG_TARGET_LEVEL: target_level_q <= cfg_wdata_i[14:0];
          uagc_pkg::REG_NOISE_FLOOR:  noise_floor_q  <= cfg_wdata_i[14:0];
          uagc_pkg::REG_MAX_GAIN:     max_gain_q     <= cfg_wdata_i;
          uagc_pkg::REG_OUTPUT_LIMIT: output_limit_q <= cfg_wdata_i[14:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    desired_q    <= desired_d;
    quot_q       <= quot_d;
    rem_q        <= rem_d;
    prod_q       <= prod_d;
    acc_q        <= acc_d;
    mag_q        <= mag_d;
    neg_q        <= neg_d;
    sample_out_q <= sample_out_d;
  end

  // assertions
  a_xfer_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == uagc_pkg::ST_ENV_MA)
    else $error("input transfer did not start the sequencer");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == uagc_pkg::ST_DIV |-> rem_q < envelope_q)
    else $error("divide remainder not below divisor");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == uagc_pkg::ST_OUT_FIN)
    else $error("result appeared outside the final step");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sample_out_o))
    else $error("pending result lost or changed");

endmodule
